/* hdl/fixed_point_to_base_n_text_core_defines.svh */
// Assertion macros for the base-N text converter.
// Included by files that carry concurrent checks; needs clk and rst in scope.
`ifndef FIXED_POINT_TO_BASE_N_TEXT_CORE_DEFINES_SVH
`define FIXED_POINT_TO_BASE_N_TEXT_CORE_DEFINES_SVH
`ifndef SYNTH
`define FTB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define FTB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FTB_ASSERT_IMP(lbl, ante, cons, msg)
`define FTB_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/ftb_pkg.sv */
// Shared constants, types and the digit alphabet of the base-N text converter.
// No dependencies; the interfaces, the design modules and the testbench import this package.
package ftb_pkg;

  localparam int INT_BITS        = 31;
  localparam int FRAC_BITS       = 32;
  localparam int RADIX_W         = 6;
  localparam int PREC_W          = 6;
  localparam int DIGIT_W         = 6;
  localparam int CHAR_W          = 8;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 6;
  localparam int RADIX_MIN       = 2;
  localparam int RADIX_MAX       = 62;
  localparam int RADIX_RESET     = 10;
  localparam int PREC_RESET      = 8;
  localparam int MAX_FRAC_DIGITS = 32;

  // Quotient bits resolved per cycle by the integer divider.
  localparam int DIV_STEPS = 4;

  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);
  localparam int ICNT_W   = $clog2(INT_BITS + 1);
  localparam int IDX_W    = $clog2(INT_BITS);
  localparam int BITCNT_W = $clog2(INT_BITS + DIV_STEPS);
  localparam int REM_W    = RADIX_W + 1;
  localparam int PROD_W   = FRAC_BITS + RADIX_W;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAC_DIGITS = CFG_IDX_W'(1);

  localparam logic [CHAR_W-1:0] CHAR_DOT = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;

  // One conversion job as it waits between front and back.
  typedef struct packed {
    logic [RADIX_W-1:0]   radix;
    logic [PREC_W-1:0]    prec;
    logic [INT_BITS-1:0]  int_part;
    logic [FRAC_BITS-1:0] frac_part;
    logic                 int_zero;
    logic                 has_point;
  } ftb_job_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
  } ftb_q_stat_t;

  // Alphabet without upper-case J and K; codes past the end wrap around.
  function automatic logic [CHAR_W-1:0] digit_symbol(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    case (d) inside
      [6'd0:6'd9]:   c = 8'h30 + CHAR_W'(d);
      [6'd10:6'd18]: c = 8'h41 + CHAR_W'(d - 6'd10);
      [6'd19:6'd33]: c = 8'h4C + CHAR_W'(d - 6'd19);
      [6'd34:6'd59]: c = 8'h61 + CHAR_W'(d - 6'd34);
      6'd60:         c = 8'h40;
      6'd61:         c = 8'h5F;
      default:       c = 8'h30 + CHAR_W'(d - 6'd62);
    endcase
    return c;
  endfunction

endpackage

/* hdl/ftb_ifs.sv */
// Handshake channels of the converter: input words, text words, config writes.
// Depends on ftb_pkg for field widths.
interface ftb_item_if import ftb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [INT_BITS-1:0]  int_part;
  logic [FRAC_BITS-1:0] frac_part;
  modport source (output valid, output int_part, output frac_part, input ready);
  modport sink   (input valid, input int_part, input frac_part, output ready);
endinterface

interface ftb_text_if import ftb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              is_last;
  logic              is_empty;
  modport source (output valid, output char_out, output is_last, output is_empty,
                  input ready);
  modport sink   (input valid, input char_out, input is_last, input is_empty,
                  output ready);
endinterface

interface ftb_cfg_if import ftb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/fixed_point_to_base_n_text_core.sv */
// Fixed-point to base-N text converter, top level.
// Depends on ftb_pkg, ftb_ifs, ftb_front, ftb_back and the assertion macro header.
//
// Channels: item carries one value (int_part, frac_part); text carries one
// character word per handshake, is_last on the final word of a value and
// is_empty on the single NUL word sent for a value that gives no text. cfg
// writes radix (index 0) and frac_digits (index 1); it is always ready. The user
// must write it only while the block is idle; the block itself does not enforce this.
// Flow: a value waits in a two-entry queue; the back end then loads it,
// works out each integer digit on the shared 4-bit-per-cycle divider and
// sends the characters in order, one word per handshake. It takes the next
// value from the queue only once it is back in idle after the current one.
// Reset: radix returns to 10, frac_digits to 8, the queue and the output
// register empty. When text stalls, the current character holds, the back
// end waits, and the queue takes up to two more values before item drops ready.
`include "fixed_point_to_base_n_text_core_defines.svh"

module fixed_point_to_base_n_text_core import ftb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ftb_item_if.sink   item,
  ftb_cfg_if.sink    cfg,
  ftb_text_if.source text
);

  ftb_job_t    job;
  logic        job_valid;
  logic        pop;
  ftb_q_stat_t q_stat;

  ftb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg       (cfg),
    .pop       (pop),
    .job       (job),
    .job_valid (job_valid),
    .q_stat    (q_stat)
  );

  ftb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .job_valid (job_valid),
    .pop       (pop),
    .text      (text)
  );

  `FTB_ASSERT_IMP(a_full_blocks_input, q_stat.full, !item.ready, "input taken while queue full")
  `FTB_ASSERT_NXT(a_accept_fills_queue, item.valid && item.ready, q_stat.count != '0, "accepted word lost")
  `FTB_ASSERT_IMP(a_empty_word_form, text.valid && text.is_empty, text.is_last && text.char_out == CHAR_NUL, "bad empty word")

endmodule

/* hdl/ftb_queue.sv */
// Short job queue that decouples the front classifier from the back sequencer.
// Depends on ftb_pkg for the job type and depth.
module ftb_queue import ftb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  ftb_job_t    push_job,
  input  logic        pop,
  output ftb_job_t    head,
  output logic        head_valid,
  output ftb_q_stat_t stat
);

  ftb_job_t          slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  assign head       = slots[rd_ptr];
  assign head_valid = (count != '0);
  assign stat.count = count;
  assign stat.full  = (count == QCNT_W'(QDEPTH));

endmodule

/* hdl/ftb_front.sv */
// Front end: configuration registers, input classification and the job queue.
// Depends on ftb_pkg, ftb_ifs and ftb_queue.
module ftb_front import ftb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ftb_item_if.sink    item,
  ftb_cfg_if.sink     cfg,
  input  logic        pop,
  output ftb_job_t    job,
  output logic        job_valid,
  output ftb_q_stat_t q_stat
);

  logic [RADIX_W-1:0] radix;
  logic [PREC_W-1:0]  frac_digits;
  ftb_job_t           new_job;
  logic               push;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix       <= RADIX_W'(RADIX_RESET);
      frac_digits <= PREC_W'(PREC_RESET);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_RADIX:       radix       <= cfg.data;
        REG_FRAC_DIGITS: frac_digits <= cfg.data;
        default: ;
      endcase
    end
  end

  // Out-of-range settings saturate to the nearest supported value.
  always_comb begin
    new_job = '0;
    if (radix < RADIX_W'(RADIX_MIN))      new_job.radix = RADIX_W'(RADIX_MIN);
    else if (radix > RADIX_W'(RADIX_MAX)) new_job.radix = RADIX_W'(RADIX_MAX);
    else                                  new_job.radix = radix;
    if (frac_digits > PREC_W'(MAX_FRAC_DIGITS)) new_job.prec = PREC_W'(MAX_FRAC_DIGITS);
    else                                        new_job.prec = frac_digits;
    new_job.int_part  = item.int_part;
    new_job.frac_part = item.frac_part;
    new_job.int_zero  = (item.int_part == '0);
    new_job.has_point = (item.frac_part != '0) || (new_job.prec == '0);
  end

  assign item.ready = !q_stat.full;
  assign push       = item.valid && item.ready;

  ftb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (new_job),
    .pop        (pop),
    .head       (job),
    .head_valid (job_valid),
    .stat       (q_stat)
  );

endmodule

/* hdl/ftb_back.sv */
// Back end: integer digit divider, fraction multiplier, digit store and text output.
// Depends on ftb_pkg and ftb_ifs.
module ftb_back import ftb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ftb_job_t   job,
  input  logic       job_valid,
  output logic       pop,
  ftb_text_if.source text
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_INT   = 6'b000100,
    S_DOT   = 6'b001000,
    S_FRAC  = 6'b010000,
    S_EMPTY = 6'b100000
  } state_t;

  state_t               state;
  logic [RADIX_W-1:0]   radix;
  logic [PREC_W-1:0]    prec;
  logic [INT_BITS-1:0]  n;
  logic [REM_W-1:0]     rem;
  logic [BITCNT_W-1:0]  bitcnt;
  logic [FRAC_BITS-1:0] frac;
  logic                 has_point;
  logic [ICNT_W-1:0]    dcnt;
  logic [ICNT_W-1:0]    rd_idx;
  logic [ICNT_W-1:0]    rd_m1;
  logic [PREC_W-1:0]    fcnt;
  logic [DIGIT_W-1:0]   store [INT_BITS];

  logic                 out_valid;
  logic [CHAR_W-1:0]    out_char;
  logic                 out_last;
  logic                 out_empty;

  logic [INT_BITS-1:0]  n_next;
  logic [REM_W-1:0]     rem_next;
  logic [REM_W-1:0]     trial;
  logic                 bit_done;
  logic [PROD_W-1:0]    prod;
  logic                 slot_free;
  logic                 emit;
  logic [CHAR_W-1:0]    emit_char;
  logic                 emit_last;
  logic                 emit_empty;

  // Restoring division by the radix, a few quotient bits per cycle. The
  // quotient shifts into n as the dividend bits shift out of it.
  always_comb begin
    n_next   = n;
    rem_next = rem;
    trial    = '0;
    for (int j = 0; j < DIV_STEPS; j++) begin
      if ((int'(bitcnt) + j) < INT_BITS) begin
        trial  = {rem_next[REM_W-2:0], n_next[INT_BITS-1]};
        n_next = {n_next[INT_BITS-2:0], 1'b0};
        if (trial >= {1'b0, radix}) begin
          rem_next  = trial - {1'b0, radix};
          n_next[0] = 1'b1;
        end else begin
          rem_next = trial;
        end
      end
    end
  end

  assign bit_done  = (int'(bitcnt) + DIV_STEPS) >= INT_BITS;
  assign prod      = PROD_W'(frac) * PROD_W'(radix);
  assign rd_m1     = rd_idx - ICNT_W'(1);
  assign slot_free = !out_valid || text.ready;
  assign pop       = (state == S_IDLE) && job_valid;

  always_comb begin
    emit       = 1'b0;
    emit_char  = CHAR_NUL;
    emit_last  = 1'b0;
    emit_empty = 1'b0;
    case (state)
      S_INT: begin
        emit      = slot_free;
        emit_char = digit_symbol(store[rd_m1[IDX_W-1:0]]);
        emit_last = (rd_idx == ICNT_W'(1)) && !has_point;
      end
      S_DOT: begin
        emit      = slot_free;
        emit_char = CHAR_DOT;
        emit_last = (prec == '0);
      end
      S_FRAC: begin
        emit      = slot_free;
        emit_char = digit_symbol(prod[PROD_W-1:FRAC_BITS]);
        emit_last = (fcnt == PREC_W'(1));
      end
      S_EMPTY: begin
        emit       = slot_free;
        emit_last  = 1'b1;
        emit_empty = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bitcnt    <= '0;
      dcnt      <= '0;
      rd_idx    <= '0;
      fcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit)            out_valid <= 1'b1;
      else if (text.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            bitcnt <= '0;
            dcnt   <= '0;
            if (!job.int_zero)     state <= S_DIV;
            else if (job.has_point) state <= S_DOT;
            else                   state <= S_EMPTY;
          end
        end
        S_DIV: begin
          if (bit_done) begin
            bitcnt <= '0;
            dcnt   <= dcnt + ICNT_W'(1);
            if (n_next == '0 || dcnt == ICNT_W'(INT_BITS - 1)) begin
              rd_idx <= dcnt + ICNT_W'(1);
              state  <= S_INT;
            end
          end else begin
            bitcnt <= bitcnt + BITCNT_W'(DIV_STEPS);
          end
        end
        S_INT: begin
          if (emit) begin
            rd_idx <= rd_m1;
            if (rd_idx == ICNT_W'(1)) state <= has_point ? S_DOT : S_IDLE;
          end
        end
        S_DOT: begin
          if (emit) begin
            fcnt  <= prec;
            state <= (prec == '0) ? S_IDLE : S_FRAC;
          end
        end
        S_FRAC: begin
          if (emit) begin
            fcnt <= fcnt - PREC_W'(1);
            if (fcnt == PREC_W'(1)) state <= S_IDLE;
          end
        end
        S_EMPTY: begin
          if (emit) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      radix     <= job.radix;
      prec      <= job.prec;
      n         <= job.int_part;
      frac      <= job.frac_part;
      has_point <= job.has_point;
      rem       <= '0;
    end else if (state == S_DIV) begin
      n   <= n_next;
      rem <= bit_done ? '0 : rem_next;
    end else if (state == S_FRAC && emit) begin
      frac <= prod[FRAC_BITS-1:0];
    end
    if (emit) begin
      out_char  <= emit_char;
      out_last  <= emit_last;
      out_empty <= emit_empty;
    end
  end

  // Digits land least significant first and are read back in reverse.
  always_ff @(posedge clk) begin
    if (state == S_DIV && bit_done) store[dcnt[IDX_W-1:0]] <= rem_next[DIGIT_W-1:0];
  end

  assign text.valid    = out_valid;
  assign text.char_out = out_char;
  assign text.is_last  = out_last;
  assign text.is_empty = out_empty;

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// Testbench for fixed_point_to_base_n_text_core: drives values and register writes,
// predicts the digit text of every value and checks each text word in order.
// Depends on ftb_pkg and the channel interfaces in ftb_ifs.
module tb import ftb_pkg::*; ();

  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 16;
  localparam int SIDE_SEND   = 0;
  localparam int SIDE_RECV   = 1;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              is_last;
    logic              is_empty;
  } text_word_t;

  class text_predictor;
    text_word_t         pending_text[$];
    logic [RADIX_W-1:0] radix_reg;
    logic [PREC_W-1:0]  frac_digits_reg;
    string              alphabet;
    int                 errors;
    int                 values_seen;
    int                 words_checked;

    function new();
      radix_reg       = RADIX_W'(RADIX_RESET);
      frac_digits_reg = PREC_W'(PREC_RESET);
      alphabet        = "0123456789ABCDEFGHILMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz@_";
      errors          = 0;
      values_seen     = 0;
      words_checked   = 0;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_RADIX) begin
        radix_reg = val;
      end else if (idx == REG_FRAC_DIGITS) begin
        frac_digits_reg = val;
      end
    endfunction

    function void push_word(logic [CHAR_W-1:0] c, logic last, logic empty);
      text_word_t w;
      w.char_out = c;
      w.is_last  = last;
      w.is_empty = empty;
      pending_text = {pending_text, w};
    endfunction

    // Works out the whole text of one accepted value.
    function void predict_text(logic [INT_BITS-1:0] int_part, logic [FRAC_BITS-1:0] frac_part);
      int unsigned         base;
      int unsigned         places;
      logic [INT_BITS-1:0] rest;
      logic [63:0]         frac;
      logic [63:0]         prod;
      int unsigned         int_digits[$];
      int                  count;
      base   = 32'(radix_reg);
      places = 32'(frac_digits_reg);
      if (base < RADIX_MIN) base = RADIX_MIN;
      if (base > RADIX_MAX) base = RADIX_MAX;
      if (places > MAX_FRAC_DIGITS) places = MAX_FRAC_DIGITS;
      count = 0;
      values_seen++;
      rest = int_part;
      while (rest != 0) begin
        int_digits.push_front(rest % base);
        rest = INT_BITS'(rest / base);
      end
      foreach (int_digits[i]) begin
        push_word(alphabet[int_digits[i]], 1'b0, 1'b0);
        count++;
      end
      if (frac_part != 0 || places == 0) begin
        push_word(CHAR_DOT, 1'b0, 1'b0);
        count++;
        frac = 64'(frac_part);
        for (int i = 0; i < places; i++) begin
          prod = frac * 64'(base);
          push_word(alphabet[prod[63:32]], 1'b0, 1'b0);
          frac = {32'b0, prod[31:0]};
          count++;
        end
      end
      if (count == 0) begin
        push_word(CHAR_NUL, 1'b1, 1'b1);
      end else begin
        pending_text[pending_text.size() - 1].is_last = 1'b1;
      end
    endfunction

    function void check_word(logic [CHAR_W-1:0] c, logic last, logic empty);
      text_word_t want;
      if (pending_text.size() == 0) begin
        $error("text word with nothing expected: char_out=%h is_last=%b is_empty=%b",
               c, last, empty);
        errors++;
        return;
      end
      want = pending_text.pop_front();
      words_checked++;
      if (c !== want.char_out) begin
        $error("char_out: expected %h, got %h", want.char_out, c);
        errors++;
      end
      if (last !== want.is_last) begin
        $error("is_last: expected %b, got %b", want.is_last, last);
        errors++;
      end
      if (empty !== want.is_empty) begin
        $error("is_empty: expected %b, got %b", want.is_empty, empty);
        errors++;
      end
    endfunction

    function int pending();
      return pending_text.size();
    endfunction

    function void check_drained();
      if (pending_text.size() != 0) begin
        $error("%0d text words never arrived", pending_text.size());
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   hold_req;
  int   calm_items[2];
  int   settings_used;
  text_predictor predictor;

  ftb_item_if item_ch ();
  ftb_text_if text_ch ();
  ftb_cfg_if  cfg_ch ();

  fixed_point_to_base_n_text_core i_dut (
    .clk  (clk),
    .rst  (rst),
    .item (item_ch),
    .cfg  (cfg_ch),
    .text (text_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle cycles before a word, with occasional stretches of back-to-back words.
  function automatic int draw_gap(int side);
    if (calm_items[side] > 0) begin
      calm_items[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm_items[side] = $urandom_range(10, 30);
    return $urandom_range(0, 6);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) predictor.note_config(cfg_ch.index, cfg_ch.data);
      if (item_ch.valid && item_ch.ready)
        predictor.predict_text(item_ch.int_part, item_ch.frac_part);
      if (text_ch.valid && text_ch.ready)
        predictor.check_word(text_ch.char_out, text_ch.is_last, text_ch.is_empty);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (text_ch.valid && text_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready) || rst) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb: errors");
    $finish;
  end

  // Text side: a random wait before each word, and one long hold-off on request.
  initial begin
    int gap;
    text_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap = LONG_HOLD;
      end else begin
        gap = draw_gap(SIDE_RECV);
      end
      if (gap > 0) begin
        text_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      text_ch.ready <= 1'b1;
      do @(posedge clk); while (!(text_ch.valid && text_ch.ready));
    end
  end

  task automatic send_value(input logic [INT_BITS-1:0] int_part,
                            input logic [FRAC_BITS-1:0] frac_part);
    int gap;
    gap = draw_gap(SIDE_SEND);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.int_part  <= int_part;
    item_ch.frac_part <= frac_part;
    do @(posedge clk); while (!(item_ch.valid && item_ch.ready));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(val);
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
  endtask

  task automatic set_config(input int radix, input int frac_digits);
    write_reg(REG_RADIX, radix);
    write_reg(REG_FRAC_DIGITS, frac_digits);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // The first edge lets the monitor take in the last accepted value.
  task automatic wait_idle(input int settle);
    @(posedge clk);
    while (predictor.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic end_phase();
    item_ch.valid <= 1'b0;
    wait_idle(SETTLE);
  endtask

  function automatic logic [INT_BITS-1:0] random_int_part();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return INT_BITS'($urandom_range(0, 1000));
      2:       return {INT_BITS{1'b1}};
      3:       return INT_BITS'(1) << $urandom_range(0, INT_BITS - 1);
      default: return INT_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [FRAC_BITS-1:0] random_frac_part();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return FRAC_BITS'($urandom_range(1, 1000));
      2:       return {FRAC_BITS{1'b1}};
      3:       return FRAC_BITS'(1) << $urandom_range(0, FRAC_BITS - 1);
      default: return FRAC_BITS'($urandom);
    endcase
  endfunction

  initial begin
    int radix;
    int frac_digits;
    predictor         = new();
    hold_req          = 1'b0;
    settings_used     = 1;
    calm_items[0]     = 0;
    calm_items[1]     = 0;
    rst               <= 1'b1;
    item_ch.valid     <= 1'b0;
    item_ch.int_part  <= '0;
    item_ch.frac_part <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= '0;
    cfg_ch.data       <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting: decimal, eight fraction digits.
    send_value('0, '0);
    send_value({INT_BITS{1'b1}}, {FRAC_BITS{1'b1}});
    send_value(31'd1, '0);
    send_value('0, 32'h8000_0000);
    send_value('0, 32'h0000_0001);
    send_value(31'd123456789, 32'h1999_999A);
    end_phase();

    // Binary gives the longest text.
    set_config(2, 32);
    send_value({INT_BITS{1'b1}}, {FRAC_BITS{1'b1}});
    send_value('0, 32'h0000_0001);
    send_value(31'd5, '0);
    end_phase();

    set_config(62, 32);
    send_value({INT_BITS{1'b1}}, {FRAC_BITS{1'b1}});
    send_value(31'd61, 32'hFC00_0000);
    send_value(31'd60, 32'h1234_5678);
    end_phase();

    // Radix below two saturates; no fraction digits leaves a bare dot.
    set_config(0, 0);
    send_value('0, '0);
    send_value(31'd6, {FRAC_BITS{1'b1}});
    end_phase();

    set_config(1, 63);
    send_value(31'd3, 32'hAAAA_AAAA);
    end_phase();

    // Radix above sixty-two and too many fraction digits both saturate.
    set_config(63, 33);
    send_value({INT_BITS{1'b1}}, 32'h0000_0001);
    send_value('0, '0);
    end_phase();

    // Digits around the missing J and K.
    set_config(36, 1);
    send_value(31'd35, {FRAC_BITS{1'b1}});
    send_value(31'd19, '0);
    send_value(31'd18, '0);
    end_phase();

    for (int phase = 0; phase < 5; phase++) begin
      radix       = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(2, 62);
      frac_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 32);
      set_config(radix, frac_digits);
      for (int n = 0; n < 20; n++) begin
        // Stall the text side long enough for the input queue to fill.
        if (phase == 1 && n == 5) hold_req = 1'b1;
        send_value(random_int_part(), random_frac_part());
      end
      end_phase();
    end

    wait_idle(40);
    predictor.check_drained();
    $display("tb: %0d values in %0d register settings, %0d text words compared",
             predictor.values_seen, settings_used, predictor.words_checked);
    if (predictor.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/ftb_pkg.sv
hdl/ftb_ifs.sv
hdl/ftb_queue.sv
hdl/ftb_front.sv
hdl/ftb_back.sv
hdl/fixed_point_to_base_n_text_core.sv
dv/tb.sv
